### hdl/pen_pkg.sv
// Package: shared types, constants and arithmetic helpers for the polynomial Newton solver.
package pen_pkg;

  localparam int MaxDegree     = 6;
  localparam int MaxIterations = 100;
  localparam int NumCoef       = MaxDegree + 1;
  localparam int DegW          = 3;
  localparam int IterW         = $clog2(MaxIterations + 1);

  localparam logic signed [63:0] SMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMin = 64'sh8000_0000_0000_0000;
  // Starting residual -999999 in Q32.32.
  localparam logic signed [63:0] StartResid = 64'shFFF0_BDC1_0000_0000;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegDegree = 3'd0;
  localparam logic [2:0] RegCoef0  = 3'd1;

  localparam logic OpEval  = 1'b0;
  localparam logic OpSolve = 1'b1;

  // One word that travels from the front part to the back part.
  typedef struct packed {
    logic              op;
    logic signed [63:0] argument;
    logic signed [63:0] start_guess;
    logic [32:0]       tol;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_CHECK, S_HMUL, S_HWAIT, S_HEND, S_DIV, S_STEP, S_DONE
  } state_t;

  // Tolerance round(2^32 / 10^d), halves up; zero for ten digits or more.
  function automatic logic [32:0] tol_of(input logic [3:0] d);
    logic [32:0] t;
    case (d)
      4'd0:    t = 33'h1_0000_0000;
      4'd1:    t = 33'd429496730;
      4'd2:    t = 33'd42949673;
      4'd3:    t = 33'd4294967;
      4'd4:    t = 33'd429497;
      4'd5:    t = 33'd42950;
      4'd6:    t = 33'd4295;
      4'd7:    t = 33'd429;
      4'd8:    t = 33'd43;
      4'd9:    t = 33'd4;
      default: t = 33'd0;
    endcase
    return t;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMin : SMax;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMin : SMax;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  // Apply a sign to a magnitude with saturation.
  function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg);
    if (neg) return m[63] ? SMin : (64'd0 - m);
    return m[63] ? SMax : m;
  endfunction

endpackage

### hdl/pen_mul.sv
// Multi-cycle saturating Q32.32 multiplier built from four 32x32 partial products.
module pen_mul
  import pen_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] product
);

  logic [2:0]   step;
  logic [31:0]  ma_lo, ma_hi, mb_lo, mb_hi;
  logic         neg;
  logic [31:0]  opa, opb;
  logic [63:0]  pp;
  logic [127:0] acc;
  logic [127:0] rnd;
  logic [63:0]  r;

  // One partial product per cycle, chosen by the step counter.
  always_comb begin
    case (step)
      3'd1:    begin opa = ma_lo; opb = mb_lo; end
      3'd2:    begin opa = ma_lo; opb = mb_hi; end
      3'd3:    begin opa = ma_hi; opb = mb_lo; end
      default: begin opa = ma_hi; opb = mb_hi; end
    endcase
  end

  always_ff @(posedge clk) begin
    pp <= opa * opb;
  end

  // Sequencer: load, four products, each accumulated in the cycle after it is formed.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= 3'd1;
      end else if (step != 3'd0) begin
        step <= (step == 3'd5) ? 3'd0 : step + 3'd1;
        if (step == 3'd5) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      {ma_hi, ma_lo} <= mag(a);
      {mb_hi, mb_lo} <= mag(b);
      neg <= a[63] ^ b[63];
      acc <= '0;
    end else begin
      case (step)
        3'd2:    acc <= acc + {64'd0, pp};
        3'd3:    acc <= acc + {32'd0, pp, 32'd0};
        3'd4:    acc <= acc + {32'd0, pp, 32'd0};
        3'd5:    acc <= acc + {pp, 64'd0};
        default: acc <= acc;
      endcase
    end
  end

  // Round half away from zero at bit 32, then saturate.
  always_comb begin
    rnd = acc + 128'h8000_0000;
    r   = rnd[95:32];
    if (rnd[127:96] != 32'd0) product = neg ? SMin : SMax;
    else                      product = from_mag(r, neg);
  end

endmodule

### hdl/pen_div.sv
// Restoring divider for saturating Q32.32 division, one quotient bit per cycle.
module pen_div
  import pen_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic signed [63:0] quot
);

  logic [95:0] sh;
  logic [64:0] rem;
  logic [63:0] dm;
  logic [63:0] q;
  logic        over, neg, busy;
  logic [6:0]  cnt;
  logic [64:0] trial;

  assign trial = {rem[63:0], sh[95]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 7'd95) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift in one numerator bit a cycle and subtract when it fits.
  always_ff @(posedge clk) begin
    if (start) begin
      sh   <= {mag(num), 32'd0};
      dm   <= mag(den);
      rem  <= '0;
      q    <= '0;
      over <= 1'b0;
      cnt  <= '0;
      neg  <= num[63] ^ den[63];
    end else if (busy) begin
      sh  <= {sh[94:0], 1'b0};
      cnt <= cnt + 7'd1;
      if (trial >= {1'b0, dm}) begin
        rem <= trial - {1'b0, dm};
        if (cnt < 7'd32) over <= 1'b1;
        else q <= {q[62:0], 1'b1};
      end else begin
        rem <= trial;
        if (cnt >= 7'd32) q <= {q[62:0], 1'b0};
      end
    end
  end

  assign quot = from_mag(over ? 64'hFFFF_FFFF_FFFF_FFFF : q, neg);

endmodule

### hdl/pen_front.sv
// Front part: accepts items, forms the tolerance and holds a two-entry job queue.
module pen_front
  import pen_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               op,
  input  logic signed [63:0] argument,
  input  logic signed [63:0] start_guess,
  input  logic [3:0]         precision_digits,
  output logic               job_valid,
  input  logic               job_take,
  output job_t               job
);

  job_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       wr, rd;

  assign full      = (cnt == 2'd2);
  assign job_valid = (cnt != 2'd0);
  assign job       = q[rp];
  assign wr        = push && !full;
  assign rd        = job_take && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

  // Store the word together with its tolerance.
  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp] <= '{op: op, argument: argument, start_guess: start_guess,
                 tol: tol_of(precision_digits)};
    end
  end

endmodule

### hdl/pen_back.sv
// Back part: Horner evaluation and Newton iteration sequencer with an output register.
module pen_back
  import pen_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_take,
  input  job_t               job,
  input  logic [DegW-1:0]    degree,
  input  logic signed [63:0] coef [NumCoef],
  output logic               empty,
  input  logic               pop,
  output logic signed [63:0] value
);

  state_t state, state_next;
  logic               op;
  logic signed [63:0] arg, x, resid, acc;
  logic [32:0]        tol;
  logic [IterW-1:0]   iter;
  logic [DegW-1:0]    deg, k, kprev;
  logic               pass;          // 0 residual or value pass, 1 slope pass
  logic signed [63:0] shifted0;
  logic signed [63:0] deriv [MaxDegree];
  logic               mul_start, mul_done, div_start, div_done;
  logic signed [63:0] prod, quo, cval, xin;
  logic               out_full;
  logic               more;

  assign empty = !out_full;
  assign xin   = (op == OpSolve) ? x : arg;
  assign kprev = k - 1'b1;
  // Another Newton step is due while under the limit and the residual is too large.
  assign more  = (iter < IterW'(MaxIterations)) && ({31'd0, tol} < mag(resid));

  // Saturated n*c for the derivative coefficients.
  function automatic logic signed [63:0] scaled(input logic signed [63:0] c,
                                                input logic [DegW-1:0] n);
    logic signed [67:0] m;
    m = c * $signed({1'b0, n});
    if (m[67:63] != {5{m[67]}}) return m[67] ? SMin : SMax;
    return m[63:0];
  endfunction

  // Derivative coefficients and the shifted constant term, formed once per job.
  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      for (int i = 0; i < MaxDegree; i++) deriv[i] <= scaled(coef[i + 1], DegW'(i + 1));
      shifted0 <= sat_sub(coef[0], arg);
    end
  end

  // Coefficient added at the current Horner step.
  always_comb begin
    if (op == OpEval)     cval = coef[kprev];
    else if (pass)        cval = deriv[kprev];
    else if (kprev == '0) cval = shifted0;
    else                  cval = coef[kprev];
  end

  pen_mul u_mul (.clk, .rst, .start(mul_start), .a(acc), .b(xin),
                 .done(mul_done), .product(prod));
  pen_div u_div (.clk, .rst, .start(div_start), .num(resid), .den(acc),
                 .done(div_done), .quot(quo));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (job_valid && !out_full) state_next = S_PREP;
      S_PREP:  state_next = S_CHECK;
      S_CHECK: begin
        if (op == OpSolve && !more) state_next = S_DONE;
        else if (deg == '0)         state_next = S_HEND;
        else                        state_next = S_HMUL;
      end
      S_HMUL:  state_next = S_HWAIT;
      S_HWAIT: if (mul_done) state_next = (k == DegW'(1)) ? S_HEND : S_HMUL;
      S_HEND: begin
        if (op == OpEval) state_next = S_DONE;
        else if (!pass) begin
          if (deg == '0)            state_next = S_STEP;
          else if (deg == DegW'(1)) state_next = S_HEND;
          else                      state_next = S_HMUL;
        end else if (acc != '0) state_next = S_DIV;
        else                    state_next = S_STEP;
      end
      S_DIV:   if (div_done) state_next = S_STEP;
      S_STEP:  state_next = S_CHECK;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    job_take  = (state == S_IDLE) && job_valid && !out_full;
    mul_start = (state == S_HMUL);
    div_start = (state == S_HEND) && (op == OpSolve) && pass && (acc != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (job_take) begin
        op    <= job.op;
        arg   <= job.argument;
        x     <= job.start_guess;
        tol   <= job.tol;
        deg   <= (degree > DegW'(MaxDegree)) ? DegW'(MaxDegree) : degree;
        iter  <= '0;
        resid <= StartResid;
      end
      S_CHECK: begin
        pass <= 1'b0;
        k    <= deg;
        acc  <= (op == OpSolve && deg == '0) ? shifted0 : coef[deg];
      end
      S_HWAIT: if (mul_done) begin
        acc <= sat_add(prod, cval);
        k   <= kprev;
      end
      S_HEND: if (op == OpSolve && !pass) begin
        resid <= acc;
        pass  <= 1'b1;
        k     <= deg - 1'b1;
        if (deg != '0) acc <= deriv[deg - 1'b1];
      end
      S_DIV:   if (div_done) x <= sat_sub(x, quo);
      S_STEP:  iter <= iter + 1'b1;
      default: ;
    endcase
  end

  // Output register: holds the result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) out_full <= 1'b0;
    else if (state == S_DONE) out_full <= 1'b1;
    else if (pop) out_full <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) value <= (op == OpSolve) ? x : acc;
  end

endmodule

### hdl/polynomial_eval_newton_inverse.sv
// Top level: configuration registers, front queue and back solver of the polynomial block.
//
//  channel  | handshake            | word
//  ---------+----------------------+-----------------------------------------------
//  input    | push / full          | op, argument, start_guess, precision_digits
//  result   | empty / pop          | value
//  config   | psel penable pwrite  | paddr, pwdata (64 bits), prdata
//
// Evaluation is one Horner pass from the job take to the result register; each
// Horner step waits on the four-product multiplier.
// A solve iteration runs two Horner passes and a divide when the slope is nonzero,
// with at most 100 iterations.
// Reset is synchronous; it clears the configuration and control registers and the queues.
// The front queue holds two words, so input is taken while the back part works
// and while a finished result waits in the output register.
module polynomial_eval_newton_inverse
  import pen_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               op,
  input  logic signed [63:0] argument,
  input  logic signed [63:0] start_guess,
  input  logic [3:0]         precision_digits,
  output logic               empty,
  input  logic               pop,
  output logic signed [63:0] value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  logic [DegW-1:0]    degree;
  logic signed [63:0] coef [NumCoef];
  logic [2:0]         ridx;
  logic               job_valid, job_take;
  job_t               job;

  assign pready = 1'b1;
  assign ridx   = paddr[5:3];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= '0;
      for (int i = 0; i < NumCoef; i++) coef[i] <= '0;
    end else if (psel && penable && pwrite) begin
      if (ridx == RegDegree) degree <= pwdata[DegW-1:0];
      else coef[ridx - RegCoef0] <= pwdata;
    end
  end

  // Register reads.
  always_comb begin
    if (ridx == RegDegree) prdata = {61'd0, degree};
    else prdata = coef[ridx - RegCoef0];
  end

  pen_front u_front (.clk, .rst, .push, .full, .op, .argument, .start_guess,
                     .precision_digits, .job_valid, .job_take, .job);

  pen_back u_back (.clk, .rst, .job_valid, .job_take, .job, .degree, .coef,
                   .empty, .pop, .value);

  // A full queue never reports itself empty of jobs.
  a_full_valid: assert property (@(posedge clk) disable iff (rst) full |-> job_valid)
    else $error("queue full without pending job");

  // A taken job with no push leaves the queue not full in the next cycle.
  a_take_room: assert property (@(posedge clk) disable iff (rst)
                                (job_take && !push) |=> !full)
    else $error("queue still full after a take");

  // A waiting result stays put until it is popped.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
                               (!empty && !pop) |=> (!empty && $stable(value)))
    else $error("result changed while waiting");

endmodule

### tb/tb_polynomial_eval_newton_inverse.sv
// Testbench for the polynomial evaluator and Newton solver: directed table, stall phase, random phases, checker.
module tb_polynomial_eval_newton_inverse
  import pen_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [63:0] QMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] QMin = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] QOne = 64'sh0000_0001_0000_0000;
  localparam int HoldCycles = 300;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic               op = OpEval;
  logic signed [63:0] argument = '0;
  logic signed [63:0] start_guess = '0;
  logic [3:0]         precision_digits = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [63:0] value;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [5:0]         paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;

  polynomial_eval_newton_inverse u_top (.*);

  always #1 clk = ~clk;

  // Shadow copy of the configuration registers.
  logic [2:0]         shadow_degree = '0;
  logic signed [63:0] shadow_coef [NumCoef];

  logic signed [63:0] expected_values [$];
  int                 fail_count = 0;
  logic               fixed_valid = 1'b0;
  logic signed [63:0] fixed_value = '0;
  int                 burst_left = 0;
  int                 stall_requests = 0;

  // ---------------- fixed-point predictor ----------------
  function automatic logic [63:0] q_abs(input logic signed [63:0] a);
    return a[63] ? 64'd0 - a : a;
  endfunction

  function automatic logic signed [63:0] q_signed(input logic [63:0] m, input logic neg);
    if (neg) return m[63] ? QMin : -$signed(m);
    return m[63] ? QMax : $signed(m);
  endfunction

  function automatic logic signed [63:0] q_add(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > $signed({QMax[63], QMax})) return QMax;
    if (s < $signed({QMin[63], QMin})) return QMin;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] q_sub(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) - $signed({b[63], b});
    if (s > $signed({QMax[63], QMax})) return QMax;
    if (s < $signed({QMin[63], QMin})) return QMin;
    return s[63:0];
  endfunction

  // Product rounded half away from zero at bit 32, then saturated.
  function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic [127:0] p;
    logic         neg;
    neg = a[63] ^ b[63];
    p = {64'd0, q_abs(a)} * {64'd0, q_abs(b)};
    p = p + 128'h8000_0000;
    if (p[127:96] != 0) return neg ? QMin : QMax;
    return q_signed(p[95:32], neg);
  endfunction

  // Quotient (f * 2^32) / d truncated toward zero; d is never zero here.
  function automatic logic signed [63:0] q_div(input logic signed [63:0] f,
                                               input logic signed [63:0] d);
    logic [95:0] q;
    logic [63:0] m;
    q = {q_abs(f), 32'd0} / {32'd0, q_abs(d)};
    m = (q[95:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
    return q_signed(m, f[63] ^ d[63]);
  endfunction

  function automatic logic signed [63:0] horner_at(input logic signed [63:0] c [NumCoef],
                                                   input int deg,
                                                   input logic signed [63:0] x);
    logic signed [63:0] acc;
    acc = c[deg];
    for (int k = deg - 1; k >= 0; k--) acc = q_add(q_mul(acc, x), c[k]);
    return acc;
  endfunction

  function automatic logic signed [63:0] predict_value(input logic o,
                                                       input logic signed [63:0] arg,
                                                       input logic signed [63:0] guess,
                                                       input logic [3:0] digits);
    logic signed [63:0] shifted [NumCoef];
    logic signed [63:0] slope_coef [NumCoef];
    logic signed [63:0] x, resid, slope, s;
    logic [63:0]        pw, tol;
    int                 deg;
    deg = (shadow_degree > MaxDegree) ? MaxDegree : shadow_degree;
    if (o == OpEval) return horner_at(shadow_coef, deg, arg);
    for (int k = 0; k < NumCoef; k++) begin
      shifted[k] = shadow_coef[k];
      slope_coef[k] = '0;
    end
    shifted[0] = q_sub(shadow_coef[0], arg);
    for (int k = 1; k <= deg; k++) begin
      s = '0;
      for (int m = 0; m < k; m++) s = q_add(s, shadow_coef[k]);
      slope_coef[k - 1] = s;
    end
    pw = 1;
    for (int i = 0; i < digits; i++) pw = pw * 10;
    tol = ((64'd1 << 32) + pw / 2) / pw;
    resid = StartResid;
    x = guess;
    for (int it = 0; it < MaxIterations && tol < q_abs(resid); it++) begin
      resid = horner_at(shifted, deg, x);
      slope = (deg > 0) ? horner_at(slope_coef, deg - 1, x) : '0;
      if (slope != 0) x = q_sub(x, q_div(resid, slope));
    end
    return x;
  endfunction

  // ---------------- monitor and checker ----------------
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full)
        expected_values = {expected_values, (fixed_valid ? fixed_value :
                           predict_value(op, argument, start_guess, precision_digits))};
      if (pop && !empty) begin
        if (expected_values.size() == 0) begin
          $display("%0t unexpected word: expected none actual %h", $time, value);
          fail_count++;
        end else begin
          if (value !== expected_values[0]) begin
            $display("%0t value mismatch: expected %h actual %h",
                     $time, expected_values[0], value);
            fail_count++;
          end
          void'(expected_values.pop_front());
        end
      end
    end
  end

  // ---------------- receiver ----------------
  initial begin
    int seen, hold, mode, mode_left;
    seen = 0; hold = 0; mode = 0; mode_left = 0;
    forever begin
      @(negedge clk);
      if (seen != stall_requests) begin
        seen = stall_requests;
        hold = HoldCycles;
      end
      if (hold > 0) begin
        pop = 1'b0;
        hold--;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (mode)
          0: pop = 1'b1;
          1: pop = $urandom_range(0, 1);
          default: pop = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------- sender and configuration tasks ----------------
  task automatic write_reg(input int idx, input logic [63:0] data);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = 6'(idx * 8); pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (idx == RegDegree) shadow_degree = data[2:0];
    else shadow_coef[idx - RegCoef0] = data;
  endtask

  // Waits until every expected word has come back and the block has settled.
  task automatic wait_idle();
    push = 1'b0;
    @(negedge clk);
    while (expected_values.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic load_poly(input logic [2:0] deg, input logic signed [63:0] c [NumCoef]);
    wait_idle();
    write_reg(RegDegree, deg);
    for (int k = 0; k < NumCoef; k++) write_reg(RegCoef0 + k, c[k]);
  endtask

  task automatic send_word(input logic o, input logic signed [63:0] arg,
                           input logic signed [63:0] guess, input logic [3:0] digits,
                           input logic has_fixed, input logic signed [63:0] fixed);
    if (burst_left == 0) begin
      push = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    op = o; argument = arg; start_guess = guess; precision_digits = digits;
    fixed_valid = has_fixed; fixed_value = fixed;
    push = 1'b1;
    do @(posedge clk); while (full);
    burst_left--;
    @(negedge clk);
  endtask

  function automatic logic signed [63:0] rand_q(input int scale_bits);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (scale_bits >= 64) return r;
    return $signed(r) >>> (64 - scale_bits);
  endfunction

  // ---------------- directed table ----------------
  typedef struct {
    int                 poly;
    logic               o;
    logic signed [63:0] arg;
    logic signed [63:0] guess;
    logic [3:0]         digits;
    logic               has_fixed;
    logic signed [63:0] fixed;
  } row_t;

  row_t rows [] = '{
    // After reset every coefficient is zero; a solve can never move its guess.
    '{0, OpEval,  QMax, 0, 0, 1, 0},
    '{0, OpEval,  QMin, 0, 0, 1, 0},
    '{0, OpSolve, QOne, QMin, 15, 1, QMin},
    '{0, OpSolve, QMax, QMax, 9, 1, QMax},
    // x^2 - 2.
    '{1, OpEval,  0, 0, 0, 1, -2 * QOne},
    '{1, OpEval,  QOne, 0, 0, 1, -QOne},
    '{1, OpEval,  QMax, 0, 0, 0, 0},
    '{1, OpEval,  QMin, 0, 0, 0, 0},
    '{1, OpSolve, 0, 0, 6, 1, 0},
    '{1, OpSolve, 0, QOne, 6, 0, 0},
    '{1, OpSolve, 0, -QOne, 0, 0, 0},
    '{1, OpSolve, 2 * QOne, 3 * QOne, 9, 0, 0},
    '{1, OpSolve, 0, QOne, 10, 0, 0},
    '{1, OpSolve, QMax, QMin, 15, 0, 0},
    // Degree register 7 acts as 6, with extreme coefficients.
    '{2, OpEval,  QOne, 0, 0, 0, 0},
    '{2, OpEval,  -QOne, 0, 0, 0, 0},
    '{2, OpEval,  QMax, 0, 0, 0, 0},
    '{2, OpSolve, QMin, QOne, 3, 0, 0},
    '{2, OpSolve, QMax, -QOne, 1, 0, 0}
  };

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic signed [63:0] c [NumCoef];
    logic [2:0]         deg;
    logic               o;
    int                 poly_now;
    for (int k = 0; k < NumCoef; k++) shadow_coef[k] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part.
    poly_now = 0;
    foreach (rows[i]) begin
      if (rows[i].poly != poly_now) begin
        poly_now = rows[i].poly;
        for (int k = 0; k < NumCoef; k++) c[k] = '0;
        if (poly_now == 1) begin
          c[0] = -2 * QOne;
          c[2] = QOne;
          load_poly(3'd2, c);
        end else begin
          c = '{QMin, QMax, -QOne, QOne, QMax, QMin, QOne};
          load_poly(3'd7, c);
        end
      end
      send_word(rows[i].o, rows[i].arg, rows[i].guess, rows[i].digits,
                rows[i].has_fixed, rows[i].fixed);
    end

    // Input back-pressure: the receiver holds off while evaluations keep coming.
    c = '{-QOne, QOne, QOne, 0, 0, 0, 0};
    load_poly(3'd2, c);
    stall_requests++;
    burst_left = 10;
    for (int i = 0; i < 10; i++) send_word(OpEval, rand_q(36), 0, 0, 1'b0, 0);

    // Random phases with fresh polynomials.
    for (int ph = 0; ph < 8; ph++) begin
      deg = (ph == 0) ? 3'd0 : (ph == 7) ? 3'd7 : 3'($urandom_range(0, 6));
      for (int k = 0; k < NumCoef; k++)
        c[k] = ($urandom_range(0, 5) == 0) ? rand_q(64) : rand_q(35);
      load_poly(deg, c);
      for (int i = 0; i < 16; i++) begin
        o = ($urandom_range(0, 9) < 3) ? OpSolve : OpEval;
        if ($urandom_range(0, 4) == 0)
          send_word(o, rand_q(64), rand_q(64), 4'($urandom), 1'b0, 0);
        else
          send_word(o, rand_q(36), rand_q(35), 4'($urandom_range(0, 5)), 1'b0, 0);
      end
    end

    // Drain and let any stray word show up.
    wait_idle();
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hdl/pen_pkg.sv
hdl/pen_mul.sv
hdl/pen_div.sv
hdl/pen_front.sv
hdl/pen_back.sv
hdl/polynomial_eval_newton_inverse.sv
tb/tb_polynomial_eval_newton_inverse.sv
